// ===== hdl/tpcm_pkg.sv =====
// Package for the transport stream PID continuity monitor.
// Holds table sizing, payload and entry structs, and controller/datapath links.
// No dependencies.
`timescale 1ns / 1ps

package tpcm_pkg;

	// PID table sizing
	localparam int PID_SLOTS  = 32;
	localparam int SLOT_W     = (PID_SLOTS > 1) ? $clog2(PID_SLOTS) : 1;
	localparam int SLOT_CNT_W = $clog2(PID_SLOTS + 1);
	localparam int IDX_OUT_W  = 5;

	// Header constants
	localparam logic [7:0]  SYNC_VALUE = 8'h47;
	localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;

	// One packet header
	typedef struct packed {
		logic [7:0]  sync_byte;
		logic [12:0] pid_value;
		logic [1:0]  scramble_control;
		logic [1:0]  adaptation_control;
		logic [3:0]  continuity_count;
		logic [7:0]  adaptation_flags;
	} in_t;

	// One check result
	typedef struct packed {
		logic        sync_error;
		logic        new_pid;
		logic        table_full;
		logic        cc_discontinuity;
		logic        scramble_changed;
		logic [4:0]  slot_index;
		logic [31:0] slot_packet_count;
		logic [31:0] packet_number;
	} out_t;

	// One PID table entry
	typedef struct packed {
		logic [12:0] pid;
		logic        scrambled;
		logic [3:0]  last_cc;
		logic [31:0] count;
	} entry_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic update;
		logic publish;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic sync_bad;
		logic hit;
		logic miss;
		logic out_free;
	} status_t;

	// Saturating increment of a packet counter
	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == COUNT_MAX) ? v : v + 32'd1;
	endfunction

	// Low bits of a slot number as reported in the result
	function automatic logic [IDX_OUT_W-1:0] slot_to_out(input logic [SLOT_W-1:0] s);
		logic [SLOT_W+IDX_OUT_W-1:0] w;
		w = {{IDX_OUT_W{1'b0}}, s};
		return w[IDX_OUT_W-1:0];
	endfunction

endpackage

// ===== hdl/ts_pid_continuity_monitor.sv =====
// Top level of the transport stream PID continuity monitor.
// Depends on tpcm_pkg, tpcm_ctrl, tpcm_datapath and tpcm_ram.
`timescale 1ns / 1ps

// Checks one transport stream packet header per request and returns one
// result per request. A request is taken while pkt_stall is low; the block
// then works on it alone. It searches the PID table one entry per cycle
// through the single read port of the entry RAM. A packet whose PID is new, or
// that finds the table full, is compared with every allocated entry; one whose
// PID matches an entry stops the search at that slot. A bad sync byte skips
// the search. The result sits in an output register and is held while
// res_stall is high; the next request is taken once that register is free.
// Table entries need no clearing after reset: only allocated slots are read.
module ts_pid_continuity_monitor import tpcm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic pkt_valid,
	output logic pkt_stall,
	input  in_t  pkt,
	output logic res_valid,
	input  logic res_stall,
	output out_t res
);

	cmd_t    cmd;
	status_t status;

	// Sequencer
	tpcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt_stall (pkt_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Table, checks and result register
	tpcm_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.pkt       (pkt),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

// ===== hdl/tpcm_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module tpcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                          wr_data,
	input  logic                                      rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                          rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== hdl/tpcm_ctrl.sv =====
// Controller for the PID continuity monitor: sequences load, table scan,
// update and result hand-off. Depends on tpcm_pkg.
`timescale 1ns / 1ps

module tpcm_ctrl import tpcm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    pkt_valid,
	output logic    pkt_stall,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_RESULT
	} state_t;

	state_t state_q;
	logic   stall_q;

	assign pkt_stall = stall_q;

	// Decode commands from state
	always_comb begin
		cmd         = '0;
		cmd.load    = (state_q == ST_IDLE) && pkt_valid && !stall_q;
		cmd.scan    = (state_q == ST_SCAN);
		cmd.update  = (state_q == ST_UPDATE);
		cmd.publish = (state_q == ST_RESULT) && status.out_free;
	end

	// Advance state; hold stall while a request is in work
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stall_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_SCAN;
						stall_q <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (status.sync_bad || status.hit || status.miss) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
						stall_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					stall_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== hdl/tpcm_datapath.sv =====
// Datapath for the PID continuity monitor: header register, table search
// through the entry RAM, checks, table update and output register.
// Depends on tpcm_pkg and tpcm_ram.
`timescale 1ns / 1ps

module tpcm_datapath import tpcm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	output status_t status,
	input  in_t     pkt,
	output logic    res_valid,
	input  logic    res_stall,
	output out_t    res
);

	localparam int ENTRY_W = $bits(entry_t);

	in_t                   item_q;
	logic [31:0]           pkt_cnt_q;
	logic [SLOT_CNT_W-1:0] used_q;
	logic [SLOT_CNT_W-1:0] scan_idx_q;
	logic                  cmp_vld_s1;
	logic [SLOT_W-1:0]     cmp_idx_s1;
	logic                  hit_q;
	entry_t                hit_entry_q;
	logic [SLOT_W-1:0]     hit_idx_q;
	out_t                  res_q;
	logic                  out_valid_q;
	out_t                  out_q;

	logic                  rd_en;
	logic [ENTRY_W-1:0]    rd_word;
	entry_t                rd_entry;
	logic                  wr_en;
	logic [SLOT_W-1:0]     wr_addr;
	entry_t                wr_entry;
	logic                  sync_ok;
	logic                  room;
	logic                  disc_ind;
	logic [3:0]            cc_step;
	logic                  alloc;
	out_t                  res_d;

	// Entry table
	tpcm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (PID_SLOTS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (scan_idx_q[SLOT_W-1:0]),
		.rd_data (rd_word)
	);

	assign rd_entry = entry_t'(rd_word);
	assign rd_en    = cmd.scan && (scan_idx_q < used_q);
	assign sync_ok  = (item_q.sync_byte == SYNC_VALUE);
	assign room     = (used_q < SLOT_CNT_W'(PID_SLOTS));
	assign disc_ind = item_q.adaptation_control[1] && item_q.adaptation_flags[7];
	assign cc_step  = item_q.continuity_count - hit_entry_q.last_cc;

	// Report search progress
	always_comb begin
		status          = '0;
		status.sync_bad = !sync_ok;
		status.hit      = cmp_vld_s1 && (rd_entry.pid == item_q.pid_value);
		status.miss     = !cmp_vld_s1 && !(scan_idx_q < used_q);
		status.out_free = !out_valid_q || !res_stall;
	end

	// Form the result and the table write
	always_comb begin
		res_d               = '0;
		res_d.packet_number = pkt_cnt_q;
		wr_entry            = '0;
		wr_entry.pid        = item_q.pid_value;
		wr_entry.scrambled  = item_q.scramble_control[1];
		wr_entry.last_cc    = item_q.continuity_count;
		wr_addr             = used_q[SLOT_W-1:0];
		alloc               = 1'b0;
		if (!sync_ok) begin
			res_d.sync_error = 1'b1;
		end else if (hit_q) begin
			res_d.cc_discontinuity  = (cc_step != 4'd1) && !disc_ind;
			res_d.scramble_changed  = (hit_entry_q.scrambled != item_q.scramble_control[1]);
			res_d.slot_index        = slot_to_out(hit_idx_q);
			res_d.slot_packet_count = sat_inc(hit_entry_q.count);
			wr_entry.count          = sat_inc(hit_entry_q.count);
			wr_addr                 = hit_idx_q;
		end else if (room) begin
			alloc                   = 1'b1;
			res_d.new_pid           = 1'b1;
			res_d.slot_index        = slot_to_out(used_q[SLOT_W-1:0]);
			res_d.slot_packet_count = 32'd1;
			wr_entry.count          = 32'd1;
		end else begin
			res_d.table_full = 1'b1;
		end
	end

	assign wr_en = cmd.update && sync_ok && (hit_q || room);

	// Control registers: counters, scan pointer, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_cnt_q   <= '0;
			used_q      <= '0;
			scan_idx_q  <= '0;
			cmp_vld_s1  <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				pkt_cnt_q  <= sat_inc(pkt_cnt_q);
				scan_idx_q <= '0;
				cmp_vld_s1 <= 1'b0;
				hit_q      <= 1'b0;
			end else if (cmd.scan) begin
				cmp_vld_s1 <= rd_en;
				if (rd_en) begin
					scan_idx_q <= scan_idx_q + SLOT_CNT_W'(1);
				end
				if (status.hit) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.update && alloc) begin
				used_q <= used_q + SLOT_CNT_W'(1);
			end
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= pkt;
		end
		if (rd_en) begin
			cmp_idx_s1 <= scan_idx_q[SLOT_W-1:0];
		end
		if (cmd.scan && status.hit && !hit_q) begin
			hit_entry_q <= rd_entry;
			hit_idx_q   <= cmp_idx_s1;
		end
		if (cmd.update) begin
			res_q <= res_d;
		end
		if (cmd.publish) begin
			out_q <= res_q;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule
